/* rtl/core/rbis_pkg.sv */
// Package: shared widths, register indexes and helper functions for the integrator.
package rbis_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIME_STEP      = 3'd0,
    REG_FRICTION_GAIN  = 3'd1,
    REG_BOUNCE_FACTOR  = 3'd2,
    REG_STOP_SPEED     = 3'd3,
    REG_GROUND_EPSILON = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               simulating;
  } body_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_acc_x;
    logic signed [31:0] new_acc_y;
    logic signed [31:0] new_acc_z;
  } body_out_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    begin
      hi = 34'sd2147483647;
      lo = -34'sd2147483648;
      if (x > hi) sat34 = 32'sh7fffffff;
      else if (x < lo) sat34 = 32'sh80000000;
      else sat34 = x[31:0];
    end
  endfunction

  // Saturate a 42-bit signed difference to 32 bits.
  function automatic logic signed [31:0] sat42(input logic signed [41:0] x);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    begin
      hi = 42'sd2147483647;
      lo = -42'sd2147483648;
      if (x > hi) sat42 = 32'sh7fffffff;
      else if (x < lo) sat42 = 32'sh80000000;
      else sat42 = x[31:0];
    end
  endfunction

  // Step product: floor(x * ts / 2^16), always fits 32 bits.
  function automatic logic signed [31:0] mul_step(input logic signed [31:0] x,
                                                  input logic [15:0] ts);
    logic signed [48:0] p;
    begin
      p = x * $signed({1'b0, ts});
      mul_step = p[47:16];
    end
  endfunction

endpackage

/* rtl/core/rbis_if.sv */
// Interfaces: valid/ready channels for body items and results.
interface rbis_in_if import rbis_pkg::*; ();
  logic     valid;
  logic     ready;
  body_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbis_out_if import rbis_pkg::*; ();
  logic      valid;
  logic      ready;
  body_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rigid_body_integrate_step.sv */
// Top level: pipelined semi-implicit Euler step for one body per beat.
//
//  channel | dir | handshake                | payload
//  in_ch   | in  | in_ch.valid/in_ch.ready  | pos, vel, acc (Q16.16), simulating
//  out_ch  | out | out_ch.valid/out_ch.ready| new pos, vel, acc (Q16.16)
//  cfg_    | in  | cfg_we                   | cfg_idx, cfg_data
//
// One beat per cycle sustained while out_ch.ready holds; nine register stages,
// with rows of 32x17, 32x18 and 32x32 multipliers spread over them.
// Reset clears the stage valid bits and loads the register reset values.
// A stall at the output freezes every stage (a single global enable), so
// in_ch.ready follows out_ch.ready whenever the last stage holds a beat.
module rigid_body_integrate_step import rbis_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  rbis_in_if.sink             in_ch,
  rbis_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int unsigned NStg = 9;

  logic [15:0] time_step_r, friction_gain_r, ground_epsilon_r;
  logic [16:0] bounce_factor_r;
  logic [30:0] stop_speed_r;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r      <= 16'd1092;
      friction_gain_r  <= 16'd0;
      bounce_factor_r  <= 17'd58982;
      stop_speed_r     <= 31'd0;
      ground_epsilon_r <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TIME_STEP:      time_step_r      <= cfg_data[15:0];
        REG_FRICTION_GAIN:  friction_gain_r  <= cfg_data[15:0];
        REG_BOUNCE_FACTOR:  bounce_factor_r  <= cfg_data[16:0];
        REG_STOP_SPEED:     stop_speed_r     <= cfg_data;
        REG_GROUND_EPSILON: ground_epsilon_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [NStg-1:0] vld_r;
  logic            adv;
  assign adv         = !vld_r[NStg-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NStg-2:0], in_ch.valid};
  end

  // Stage 1: capture item, friction products and ground test.
  typedef logic signed [31:0] w_t;
  w_t p1x_r, p1y_r, p1z_r, v1x_r, v1y_r, v1z_r, a1x_r, a1y_r, a1z_r;
  logic signed [48:0] f1x_r, f1y_r;
  logic fr1_r, sim1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1x_r <= in_ch.data.pos_x; p1y_r <= in_ch.data.pos_y; p1z_r <= in_ch.data.pos_z;
      v1x_r <= in_ch.data.vel_x; v1y_r <= in_ch.data.vel_y; v1z_r <= in_ch.data.vel_z;
      a1x_r <= in_ch.data.acc_x; a1y_r <= in_ch.data.acc_y; a1z_r <= in_ch.data.acc_z;
      sim1_r <= in_ch.data.simulating;
      f1x_r <= in_ch.data.vel_x * $signed({1'b0, friction_gain_r});
      f1y_r <= in_ch.data.vel_y * $signed({1'b0, friction_gain_r});
      fr1_r <= (in_ch.data.vel_x != 0 || in_ch.data.vel_y != 0 ||
                in_ch.data.vel_z != 0) &&
               (in_ch.data.pos_z < $signed({16'd0, ground_epsilon_r}));
    end
  end

  // Stage 2: apply friction to horizontal acceleration.
  w_t p2x_r, p2y_r, p2z_r, v2x_r, v2y_r, v2z_r, a2x_r, a2y_r, a2z_r;
  logic sim2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p2x_r <= p1x_r; p2y_r <= p1y_r; p2z_r <= p1z_r;
      v2x_r <= v1x_r; v2y_r <= v1y_r; v2z_r <= v1z_r; a2z_r <= a1z_r;
      sim2_r <= sim1_r;
      a2x_r <= fr1_r ? sat42(42'(a1x_r) - 42'($signed(f1x_r[48:8]))) : a1x_r;
      a2y_r <= fr1_r ? sat42(42'(a1y_r) - 42'($signed(f1y_r[48:8]))) : a1y_r;
    end
  end

  // Stage 3: step products dv and dot products v.a.
  w_t p3x_r, p3y_r, p3z_r, v3x_r, v3y_r, v3z_r, a3x_r, a3y_r, a3z_r;
  w_t d3x_r, d3y_r, d3z_r;
  logic signed [63:0] q3x_r, q3y_r, q3z_r;
  logic sim3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p3x_r <= p2x_r; p3y_r <= p2y_r; p3z_r <= p2z_r;
      v3x_r <= v2x_r; v3y_r <= v2y_r; v3z_r <= v2z_r;
      a3x_r <= a2x_r; a3y_r <= a2y_r; a3z_r <= a2z_r; sim3_r <= sim2_r;
      d3x_r <= mul_step(a2x_r, time_step_r);
      d3y_r <= mul_step(a2y_r, time_step_r);
      d3z_r <= mul_step(a2z_r, time_step_r);
      q3x_r <= v2x_r * a2x_r; q3y_r <= v2y_r * a2y_r; q3z_r <= v2z_r * a2z_r;
    end
  end

  // Stage 4: squares of dv and v, sign of dot.
  w_t p4x_r, p4y_r, p4z_r, v4x_r, v4y_r, v4z_r, a4x_r, a4y_r, a4z_r;
  w_t d4x_r, d4y_r, d4z_r;
  logic [63:0] sd4x_r, sd4y_r, sd4z_r, sv4x_r, sv4y_r, sv4z_r;
  logic neg4_r, sim4_r;
  logic signed [65:0] dot3;
  assign dot3 = 66'(q3x_r) + 66'(q3y_r) + 66'(q3z_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      p4x_r <= p3x_r; p4y_r <= p3y_r; p4z_r <= p3z_r;
      v4x_r <= v3x_r; v4y_r <= v3y_r; v4z_r <= v3z_r;
      a4x_r <= a3x_r; a4y_r <= a3y_r; a4z_r <= a3z_r; sim4_r <= sim3_r;
      d4x_r <= d3x_r; d4y_r <= d3y_r; d4z_r <= d3z_r;
      sd4x_r <= 64'(d3x_r) * 64'(d3x_r); sd4y_r <= 64'(d3y_r) * 64'(d3y_r);
      sd4z_r <= 64'(d3z_r) * 64'(d3z_r);
      sv4x_r <= 64'(v3x_r) * 64'(v3x_r); sv4y_r <= 64'(v3y_r) * 64'(v3y_r);
      sv4z_r <= 64'(v3z_r) * 64'(v3z_r);
      neg4_r <= dot3[65];
    end
  end

  // Stage 5: overshoot test and velocity update.
  w_t p5x_r, p5y_r, p5z_r, v5x_r, v5y_r, v5z_r, a5x_r, a5y_r, a5z_r;
  logic sim5_r;
  logic [63:0] md4, mv4;
  logic stop4;
  assign md4   = sd4x_r + sd4y_r + sd4z_r;
  assign mv4   = sv4x_r + sv4y_r + sv4z_r;
  assign stop4 = neg4_r && (md4 > mv4);
  always_ff @(posedge clk) begin
    if (adv) begin
      p5x_r <= p4x_r; p5y_r <= p4y_r; p5z_r <= p4z_r;
      a5x_r <= a4x_r; a5y_r <= a4y_r; a5z_r <= a4z_r; sim5_r <= sim4_r;
      if (!sim4_r) begin
        v5x_r <= v4x_r; v5y_r <= v4y_r; v5z_r <= v4z_r;
      end else if (stop4) begin
        v5x_r <= '0; v5y_r <= '0; v5z_r <= '0;
      end else begin
        v5x_r <= sat34(34'(v4x_r) + 34'(d4x_r));
        v5y_r <= sat34(34'(v4y_r) + 34'(d4y_r));
        v5z_r <= sat34(34'(v4z_r) + 34'(d4z_r));
      end
    end
  end

  // Stage 6: position step products and bounce product.
  w_t p6x_r, p6y_r, p6z_r, v6x_r, v6y_r, v6z_r, a6x_r, a6y_r, a6z_r;
  w_t s6x_r, s6y_r, s6z_r;
  logic signed [49:0] b6_r;
  logic sim6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p6x_r <= p5x_r; p6y_r <= p5y_r; p6z_r <= p5z_r;
      v6x_r <= v5x_r; v6y_r <= v5y_r; v6z_r <= v5z_r;
      a6x_r <= a5x_r; a6y_r <= a5y_r; a6z_r <= a5z_r; sim6_r <= sim5_r;
      s6x_r <= mul_step(v5x_r, time_step_r);
      s6y_r <= mul_step(v5y_r, time_step_r);
      s6z_r <= mul_step(v5z_r, time_step_r);
      b6_r  <= v5z_r * $signed({1'b0, bounce_factor_r});
    end
  end

  // Stage 7: position sums, floor clamp and bounced velocity.
  w_t p7x_r, p7y_r, p7z_r, v7x_r, v7y_r, v7z_r, a7x_r, a7y_r, a7z_r;
  logic bnc7_r;
  w_t nz6, vb6;
  logic signed [33:0] nb6;
  assign nz6 = sat34(34'(p6z_r) + 34'(s6z_r));
  assign nb6 = -34'(b6_r[49:16]);
  assign vb6 = sat34(nb6);
  always_ff @(posedge clk) begin
    if (adv) begin
      v7x_r <= v6x_r; v7y_r <= v6y_r;
      a7x_r <= a6x_r; a7y_r <= a6y_r; a7z_r <= a6z_r;
      if (sim6_r) begin
        p7x_r <= sat34(34'(p6x_r) + 34'(s6x_r));
        p7y_r <= sat34(34'(p6y_r) + 34'(s6y_r));
        p7z_r <= nz6[31] ? '0 : nz6;
        v7z_r <= nz6[31] ? vb6 : v6z_r;
        bnc7_r <= nz6[31];
      end else begin
        p7x_r <= p6x_r; p7y_r <= p6y_r; p7z_r <= p6z_r;
        v7z_r <= v6z_r; bnc7_r <= 1'b0;
      end
    end
  end

  // Stage 8: velocity squares after the bounce.
  w_t p8x_r, p8y_r, p8z_r, v8x_r, v8y_r, v8z_r, a8x_r, a8y_r, a8z_r;
  logic [63:0] sv8x_r, sv8y_r, sv8z_r;
  logic bnc8_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p8x_r <= p7x_r; p8y_r <= p7y_r; p8z_r <= p7z_r;
      v8x_r <= v7x_r; v8y_r <= v7y_r; v8z_r <= v7z_r;
      a8x_r <= a7x_r; a8y_r <= a7y_r; a8z_r <= a7z_r; bnc8_r <= bnc7_r;
      sv8x_r <= 64'(v7x_r) * 64'(v7x_r);
      sv8y_r <= 64'(v7y_r) * 64'(v7y_r);
      sv8z_r <= 64'(v7z_r) * 64'(v7z_r);
    end
  end

  // Stage 9: magnitude sum and stop test.
  logic [63:0] m8;
  assign m8 = sv8x_r + sv8y_r + sv8z_r;
  logic [61:0] ss8;
  assign ss8 = stop_speed_r * stop_speed_r;
  logic halt8;
  assign halt8 = bnc8_r && (m8 < 64'(ss8));

  body_out_t o_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      o_r.new_pos_x <= p8x_r; o_r.new_pos_y <= p8y_r; o_r.new_pos_z <= p8z_r;
      o_r.new_vel_x <= halt8 ? '0 : v8x_r;
      o_r.new_vel_y <= halt8 ? '0 : v8y_r;
      o_r.new_vel_z <= halt8 ? '0 : v8z_r;
      o_r.new_acc_x <= a8x_r; o_r.new_acc_y <= a8y_r; o_r.new_acc_z <= a8z_r;
    end
  end

  assign out_ch.valid = vld_r[NStg-1];
  assign out_ch.data  = o_r;

  // Check stall and clamp behavior.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result moved while stalled");
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    bnc7_r |-> p7z_r == '0)
    else $error("height not clamped to floor after bounce");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");

endmodule

/* tb/tb_rigid_body_integrate_step.sv */
// Testbench: streams bodies through the integrator and checks every result against a predictor.
module tb_rigid_body_integrate_step;
  import rbis_pkg::*;

  localparam int          LatencyCycles = 9;
  localparam int          IdleLimit     = 5000;
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;
  localparam longint      SatHi = 64'sd2147483647;
  localparam longint      SatLo = -64'sd2147483648;

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  rbis_in_if  in_ch ();
  rbis_out_if out_ch ();

  rigid_body_integrate_step dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Register copies used by the predictor
  logic [15:0] step_len;
  logic [15:0] fric_gain;
  logic [16:0] bounce_gain;
  logic [30:0] rest_speed;
  logic [15:0] floor_band;

  body_in_t  pending_bodies[$];
  body_out_t expected_bodies[$];
  int        mismatches;
  bit        calm;
  int        send_gap;
  int        stall_left;
  int        idle_cycles;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint clip32(input longint x);
    if (x > SatHi) return SatHi;
    if (x < SatLo) return SatLo;
    return x;
  endfunction

  function automatic longint scale_by_step(input longint x);
    return (x * longint'(step_len)) >>> 16;
  endfunction

  function automatic logic [67:0] energy(input longint x, input longint y, input longint z);
    logic [67:0] s;
    s = 68'(x * x) + 68'(y * y) + 68'(z * z);
    return s;
  endfunction

  // Compute the next body state from one input beat
  function automatic body_out_t integrate_body(input body_in_t b);
    longint p[3];
    longint v[3];
    longint a[3];
    longint dv[3];
    logic signed [67:0] dot;
    body_out_t r;
    p[0] = b.pos_x; p[1] = b.pos_y; p[2] = b.pos_z;
    v[0] = b.vel_x; v[1] = b.vel_y; v[2] = b.vel_z;
    a[0] = b.acc_x; a[1] = b.acc_y; a[2] = b.acc_z;
    // ground friction on a moving body touching the floor
    if ((v[0] != 0 || v[1] != 0 || v[2] != 0) && p[2] < longint'(floor_band)) begin
      for (int i = 0; i < 2; i++)
        a[i] = clip32(a[i] - ((longint'(fric_gain) * v[i]) >>> 8));
    end
    if (b.simulating) begin
      for (int i = 0; i < 3; i++) dv[i] = scale_by_step(a[i]);
      dot = 68'sd0;
      for (int i = 0; i < 3; i++) dot = dot + 68'(v[i] * a[i]);
      // stop instead of overshooting through zero
      if (dot < 0 && energy(dv[0], dv[1], dv[2]) > energy(v[0], v[1], v[2])) begin
        v[0] = 0; v[1] = 0; v[2] = 0;
      end else begin
        for (int i = 0; i < 3; i++) v[i] = clip32(v[i] + dv[i]);
      end
      for (int i = 0; i < 3; i++) p[i] = clip32(p[i] + scale_by_step(v[i]));
      // floor contact: clamp, bounce, maybe come to rest
      if (p[2] < 0) begin
        p[2] = 0;
        v[2] = clip32(-((v[2] * longint'(bounce_gain)) >>> 16));
        if (energy(v[0], v[1], v[2]) < 68'(longint'(rest_speed) * longint'(rest_speed))) begin
          v[0] = 0; v[1] = 0; v[2] = 0;
        end
      end
    end
    r.new_pos_x = p[0][31:0]; r.new_pos_y = p[1][31:0]; r.new_pos_z = p[2][31:0];
    r.new_vel_x = v[0][31:0]; r.new_vel_y = v[1][31:0]; r.new_vel_z = v[2][31:0];
    r.new_acc_x = a[0][31:0]; r.new_acc_y = a[1][31:0]; r.new_acc_z = a[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h", field, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present pending bodies, predict on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_bodies.push_back(integrate_body(in_ch.data));
        void'(pending_bodies.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_bodies.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_bodies[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat, toggle ready at random
  always @(posedge clk) begin
    body_out_t want;
    body_out_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_bodies.size() == 0) begin
          $display("unexpected result beat");
          mismatches++;
        end else begin
          want = expected_bodies.pop_front();
          if (got.new_pos_x !== want.new_pos_x) report_mismatch("pos_x", got.new_pos_x, want.new_pos_x);
          if (got.new_pos_y !== want.new_pos_y) report_mismatch("pos_y", got.new_pos_y, want.new_pos_y);
          if (got.new_pos_z !== want.new_pos_z) report_mismatch("pos_z", got.new_pos_z, want.new_pos_z);
          if (got.new_vel_x !== want.new_vel_x) report_mismatch("vel_x", got.new_vel_x, want.new_vel_x);
          if (got.new_vel_y !== want.new_vel_y) report_mismatch("vel_y", got.new_vel_y, want.new_vel_y);
          if (got.new_vel_z !== want.new_vel_z) report_mismatch("vel_z", got.new_vel_z, want.new_vel_z);
          if (got.new_acc_x !== want.new_acc_x) report_mismatch("acc_x", got.new_acc_x, want.new_acc_x);
          if (got.new_acc_y !== want.new_acc_y) report_mismatch("acc_y", got.new_acc_y, want.new_acc_y);
          if (got.new_acc_z !== want.new_acc_z) report_mismatch("acc_z", got.new_acc_z, want.new_acc_z);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("rigid_body_integrate_step regression: fail");
      $finish;
    end
  end

  // Issue one register write and mirror it in the predictor copy
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_TIME_STEP:      step_len    = val[15:0];
      REG_FRICTION_GAIN:  fric_gain   = val[15:0];
      REG_BOUNCE_FACTOR:  bounce_gain = val[16:0];
      REG_STOP_SPEED:     rest_speed  = val[30:0];
      REG_GROUND_EPSILON: floor_band  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [30:0] ts, input logic [30:0] fg, input logic [30:0] bf,
                           input logic [30:0] ss, input logic [30:0] ge);
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_FRICTION_GAIN, fg);
    write_reg(REG_BOUNCE_FACTOR, bf);
    write_reg(REG_STOP_SPEED, ss);
    write_reg(REG_GROUND_EPSILON, ge);
    write_reg(logic'($urandom_range(0, 1)) ? RegUnusedLo : RegUnusedHi, 31'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every result has come back, then let the pipe settle
  task automatic drain();
    while (pending_bodies.size() > 0 || expected_bodies.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h1 : 32'hffffffff;
      4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic body_in_t make_body(input logic [31:0] px, py, pz, vx, vy, vz,
                                         ax, ay, az, input logic sim);
    body_in_t b;
    b.pos_x = px; b.pos_y = py; b.pos_z = pz;
    b.vel_x = vx; b.vel_y = vy; b.vel_z = vz;
    b.acc_x = ax; b.acc_y = ay; b.acc_z = az;
    b.simulating = sim;
    return b;
  endfunction

  // Mostly bodies near the floor with varied motion, some pure noise
  function automatic body_in_t random_body();
    body_in_t b;
    b = make_body(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                  pick_word(), pick_word(), pick_word(), pick_word(), 1'($urandom));
    if ($urandom_range(0, 9) < 7) begin
      b.pos_z = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      b.simulating = ($urandom_range(0, 9) < 8);
      if ($urandom_range(0, 2) == 0) begin
        // acceleration opposing velocity
        b.acc_x = -b.vel_x * 32'($urandom_range(1, 200));
        b.acc_y = -b.vel_y * 32'($urandom_range(1, 200));
        b.acc_z = -b.vel_z * 32'($urandom_range(1, 200));
      end
    end
    return b;
  endfunction

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    calm         = 1'b0;
    step_len     = 16'd1092;
    fric_gain    = 16'd0;
    bounce_gain  = 17'd58982;
    rest_speed   = 31'd0;
    floor_band   = 16'd7;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bodies at reset settings
    pending_bodies.push_back(make_body(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    pending_bodies.push_back(make_body(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
    pending_bodies.push_back(make_body(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
    pending_bodies.push_back(make_body(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    drain();

    // Directed bodies with friction, bounce and stop speed active
    load_regs(31'd1092, 31'd512, 31'd58982, 31'd65536, 31'd65535);
    // not simulating: friction only
    pending_bodies.push_back(make_body(5, 6, 100, 32'h10000, 32'hfffe0000, 0, 7, 8, 9, 1'b0));
    // moving but above the floor band
    pending_bodies.push_back(make_body(0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0, 0, 1'b1));
    // at rest on the floor: no friction
    pending_bodies.push_back(make_body(0, 0, 0, 0, 0, 0, 32'h50000, 0, 32'hfff60000, 1'b1));
    // opposing acceleration that overshoots
    pending_bodies.push_back(make_body(0, 0, 32'h100000, 32'h100, 0, 0, 32'h80000000, 0, 0, 1'b1));
    // opposing acceleration that does not overshoot
    pending_bodies.push_back(make_body(0, 0, 32'h100000, 32'h100000, 0, 0, 32'hffff0000, 0, 0, 1'b1));
    // fast fall through the floor: bounce
    pending_bodies.push_back(make_body(0, 0, 32'h100, 0, 0, 32'hff000000, 0, 0, 0, 1'b1));
    // slow fall through the floor: come to rest
    pending_bodies.push_back(make_body(0, 0, 1, 0, 0, 32'hffff8000, 0, 0, 0, 1'b1));
    // saturating position sum
    pending_bodies.push_back(make_body(32'h7fffff00, 32'h80000100, 32'h7fffff00, 32'h7fffffff,
      32'h80000000, 32'h7fffffff, 0, 0, 0, 1'b1));
    drain();

    // Restitution above one and widest registers
    load_regs(31'h7fffffff, 31'h7fffffff, 31'd131071, 31'h7fffffff, 31'h7fffffff);
    pending_bodies.push_back(make_body(0, 0, 32'h10, 0, 0, 32'h80000000, 0, 0, 0, 1'b1));
    pending_bodies.push_back(make_body(0, 0, 32'hffff0000, 32'h7fffffff, 32'h80000000,
      32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1));
    drain();

    // Random phases over a spread of settings
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: load_regs(31'd1092, 31'd0, 31'd58982, 31'd0, 31'd7);
        1: load_regs(31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
        2: load_regs(31'd65535, 31'd65535, 31'd65536, 31'h7fffffff, 31'd65535);
        3: load_regs(31'd1092, 31'd300, 31'd65536, 31'd4096, 31'd65535);
        default: load_regs(31'($urandom), 31'($urandom), 31'($urandom_range(0, 131071)),
                           ($urandom_range(0, 1) ? 31'($urandom_range(0, 1 << 20)) : 31'($urandom)),
                           31'($urandom));
      endcase
      for (int k = 0; k < 125; k++) pending_bodies.push_back(random_body());
      drain();
    end

    if (mismatches == 0) begin
      $display("rigid_body_integrate_step regression: pass");
    end else begin
      $display("rigid_body_integrate_step regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rbis_pkg.sv
rtl/core/rbis_if.sv
rtl/core/rigid_body_integrate_step.sv
tb/tb_rigid_body_integrate_step.sv
